// ===== hdl/shdt_pkg.sv =====
// Shared types and constants for the string hash direct-mapped table.
`timescale 1ns / 1ps
package shdt_pkg;

  localparam int HASH_W   = 64;   // running hash width
  localparam int HASH_CNT_W = 6;  // remainder steps, one hash bit each
  localparam int ENT_W    = 9;    // table_entries register width
  localparam int EB_W     = 4;    // element_bytes register width
  localparam int CFG_W    = 9;    // widest config register
  localparam int CFG_IDX_W = 2;
  localparam int SLOT_W   = 8;    // slot_index port width
  localparam int DATA_W   = 64;   // value port width

  // Operation codes carried on the last item
  localparam logic [2:0] MODE_SET_VAL = 3'd0;
  localparam logic [2:0] MODE_GET_VAL = 3'd1;
  localparam logic [2:0] MODE_SET_PTR = 3'd2;
  localparam logic [2:0] MODE_GET_PTR = 3'd3;
  localparam logic [2:0] MODE_FILL    = 3'd4;

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TABLE_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMENT_BYTES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_POINTER_MODE  = 2'd2;

  localparam logic [ENT_W-1:0] TABLE_ENTRIES_RST = 9'd256;
  localparam logic [EB_W-1:0]  ELEMENT_BYTES_RST = 4'd8;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_EXEC,
    ST_FILL,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic accept;      // input item taken this cycle
    logic div_step;    // one remainder step
    logic issue;       // store write (set) or read (get) at the slot
    logic clear_step;  // zero one entry during the power-up sweep
    logic fill_step;   // write one entry of a fill
    logic out_load;    // load the result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_last;
    logic type_err;
    logic is_fill;
    logic clear_last;
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage

// ===== hdl/shdt_ctrl.sv =====
// Controller state machine for the string hash direct-mapped table.
`timescale 1ns / 1ps
module shdt_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_last_char,
  input  shdt_pkg::dp_status_t   st,
  output shdt_pkg::ctrl_cmd_t    cmd,
  output logic                   in_stall
);
  import shdt_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (st.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid && in_last_char) state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (st.div_last) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        if (!st.type_err && st.is_fill) state_nxt = ST_FILL;
        else state_nxt = ST_RESULT;
      end
      ST_FILL: begin
        if (st.fill_last) state_nxt = ST_RESULT;
      end
      ST_RESULT: begin
        if (st.out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state_r)
      ST_CLEAR: cmd.clear_step = 1'b1;
      ST_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      ST_DIV:  cmd.div_step = 1'b1;
      ST_EXEC: cmd.issue = !st.type_err && !st.is_fill;
      ST_FILL: cmd.fill_step = 1'b1;
      ST_RESULT: cmd.out_load = st.out_free;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== hdl/shdt_datapath.sv =====
// Datapath: config registers, hash fold, serial remainder, slot store, result register.
`timescale 1ns / 1ps
module shdt_datapath #(
  parameter int MAX_ENTRIES = 256,
  parameter int VALUE_BITS  = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [shdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shdt_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic [2:0]                       in_mode,
  input  logic [7:0]                       in_key_char,
  input  logic                             in_char_present,
  input  logic                             in_last_char,
  input  logic [shdt_pkg::DATA_W-1:0]      in_write_value,
  input  logic                             out_stall,
  input  shdt_pkg::ctrl_cmd_t              cmd,
  output shdt_pkg::dp_status_t             st,
  output logic                             out_valid,
  output logic [shdt_pkg::DATA_W-1:0]      out_read_value,
  output logic                             out_status,
  output logic [shdt_pkg::SLOT_W-1:0]      out_slot_index
);
  import shdt_pkg::*;

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam logic [AW-1:0] CLEAR_LAST = AW'(MAX_ENTRIES - 1);

  // config
  logic [ENT_W-1:0] table_entries_r;
  logic [EB_W-1:0]  element_bytes_r;
  logic             pointer_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_entries_r <= TABLE_ENTRIES_RST;
      element_bytes_r <= ELEMENT_BYTES_RST;
      pointer_mode_r  <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_TABLE_ENTRIES: table_entries_r <= cfg_wdata;
        CFG_ELEMENT_BYTES: element_bytes_r <= cfg_wdata[EB_W-1:0];
        CFG_POINTER_MODE:  pointer_mode_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective entry count and value mask
  logic [ENT_W-1:0]      n_eff;
  logic [EB_W-1:0]       eb_eff;
  logic [DATA_W-1:0]     byte_mask;
  logic [VALUE_BITS-1:0] vmask;
  logic [AW-1:0]         fill_last_addr;

  always_comb begin
    if (table_entries_r == '0) n_eff = ENT_W'(1);
    else if (int'(table_entries_r) > MAX_ENTRIES) n_eff = ENT_W'(MAX_ENTRIES);
    else n_eff = table_entries_r;

    if (element_bytes_r == '0) eb_eff = EB_W'(1);
    else if (element_bytes_r > EB_W'(8)) eb_eff = EB_W'(8);
    else eb_eff = element_bytes_r;

    for (int k = 0; k < 8; k++) begin
      byte_mask[8*k +: 8] = (EB_W'(k) < eb_eff) ? 8'hFF : 8'h00;
    end
    vmask          = byte_mask[VALUE_BITS-1:0];
    fill_last_addr = AW'(n_eff - ENT_W'(1));
  end

  // running hash: hash * 97 + char, built from shifts
  logic [HASH_W-1:0]     hash_r;
  logic [HASH_W-1:0]     hash_fold;
  logic [2:0]            mode_r;
  logic [DATA_W-1:0]     wval_r;
  logic [ENT_W-1:0]      rem_r;
  logic [HASH_CNT_W-1:0] div_cnt_r;
  logic [ENT_W:0]        rem_shift;
  logic [ENT_W:0]        rem_sub;

  assign hash_fold = in_char_present
                   ? (hash_r << 6) + (hash_r << 5) + hash_r + HASH_W'(in_key_char)
                   : hash_r;

  // restoring remainder, one hash bit per step
  assign rem_shift = {rem_r, hash_r[HASH_W-1]};
  assign rem_sub   = rem_shift - {1'b0, n_eff};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r    <= '0;
      div_cnt_r <= '0;
    end else if (cmd.accept) begin
      hash_r    <= hash_fold;
      div_cnt_r <= '0;
    end else if (cmd.div_step) begin
      // after all steps the hash has shifted out to zero
      hash_r    <= hash_r << 1;
      div_cnt_r <= div_cnt_r + HASH_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_last_char) begin
      mode_r <= in_mode;
      wval_r <= in_write_value;
      rem_r  <= '0;
    end else if (cmd.div_step) begin
      rem_r <= (rem_shift >= {1'b0, n_eff}) ? rem_sub[ENT_W-1:0] : rem_shift[ENT_W-1:0];
    end
  end

  // operation decode
  logic type_err;
  logic is_fill;
  logic is_set;
  logic is_get;

  always_comb begin
    is_fill = (mode_r == MODE_FILL);
    is_set  = (mode_r == MODE_SET_VAL) || (mode_r == MODE_SET_PTR);
    is_get  = (mode_r == MODE_GET_VAL) || (mode_r == MODE_GET_PTR);
    unique case (mode_r)
      MODE_SET_VAL, MODE_GET_VAL, MODE_FILL: type_err = pointer_mode_r;
      MODE_SET_PTR, MODE_GET_PTR:            type_err = !pointer_mode_r;
      default:                               type_err = 1'b1;
    endcase
  end

  // sweep counter for power-up clear and fill
  logic [AW-1:0] sweep_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.clear_step || cmd.fill_step) begin
      sweep_r <= sweep_r + AW'(1);
    end else begin
      sweep_r <= '0;
    end
  end

  // slot store
  logic [VALUE_BITS-1:0] mem [MAX_ENTRIES];
  logic [VALUE_BITS-1:0] rd_data_r;
  logic                  mem_we;
  logic [AW-1:0]         mem_wa;
  logic [VALUE_BITS-1:0] mem_wd;
  logic [AW-1:0]         slot_addr;

  assign slot_addr = AW'(rem_r);

  always_comb begin
    mem_we = 1'b0;
    mem_wa = sweep_r;
    mem_wd = '0;
    priority if (cmd.clear_step) begin
      mem_we = 1'b1;
    end else if (cmd.fill_step) begin
      mem_we = 1'b1;
      mem_wd = wval_r[VALUE_BITS-1:0] & vmask;
    end else if (cmd.issue && is_set) begin
      mem_we = 1'b1;
      mem_wa = slot_addr;
      mem_wd = (mode_r == MODE_SET_VAL) ? (wval_r[VALUE_BITS-1:0] & vmask)
                                        : wval_r[VALUE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (cmd.issue) rd_data_r <= mem[slot_addr];
  end

  // result register
  logic              out_valid_r;
  logic [DATA_W-1:0] out_read_value_r;
  logic              out_status_r;
  logic [SLOT_W-1:0] out_slot_index_r;
  logic [DATA_W-1:0] rd_value;

  always_comb begin
    if (type_err || !is_get) rd_value = '0;
    else if (mode_r == MODE_GET_VAL) rd_value = DATA_W'(rd_data_r & vmask);
    else rd_value = DATA_W'(rd_data_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_read_value_r <= rd_value;
      out_status_r     <= type_err;
      out_slot_index_r <= is_fill ? '0 : rem_r[SLOT_W-1:0];
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_value = out_read_value_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_index_r;

  always_comb begin
    st.div_last   = &div_cnt_r;
    st.type_err   = type_err;
    st.is_fill    = is_fill;
    st.clear_last = (sweep_r == CLEAR_LAST);
    st.fill_last  = (sweep_r == fill_last_addr);
    st.out_free   = !out_valid_r || !out_stall;
  end

endmodule

// ===== hdl/string_hash_direct_table.sv =====
// Top level of the string hash direct-mapped table.
//
//   channel   direction  handshake                payload
//   in_*      input      in_valid / in_stall      mode, key_char, char_present, last_char,
//                                                 write_value
//   out_*     output     out_valid / out_stall    read_value, status, slot_index
//   cfg_*     input      cfg_wr_en (no wait)      cfg_index, cfg_wdata
//
// A key item that is not the last has its character folded into the 64-bit
// hash (hash * 97 + char) in the cycle it is accepted. For the last item
// the hash is reduced modulo the entry count by a serial remainder unit,
// one hash bit per cycle, then the store is written or read, then the result
// register loads. A fill writes each slot of the effective entry count in turn.
// After reset the store is zeroed by a sweep over all MAX_ENTRIES slots; in_stall is
// high meanwhile. The result register decouples out_stall from the input side
// while an item still folds; a new result waits until the previous one is taken.
`timescale 1ns / 1ps
module string_hash_direct_table #(
  parameter int MAX_ENTRIES = 256,
  parameter int VALUE_BITS  = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [shdt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [shdt_pkg::CFG_W-1:0]       cfg_wdata,
  // input items
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [2:0]                       in_mode,
  input  logic [7:0]                       in_key_char,
  input  logic                             in_char_present,
  input  logic                             in_last_char,
  input  logic [shdt_pkg::DATA_W-1:0]      in_write_value,
  // result items
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [shdt_pkg::DATA_W-1:0]      out_read_value,
  output logic                             out_status,
  output logic [shdt_pkg::SLOT_W-1:0]      out_slot_index
);
  import shdt_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  // sequencing: clear sweep, key folding, remainder, store access, fill, result
  shdt_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_char (in_last_char),
    .st           (st),
    .cmd          (cmd),
    .in_stall     (in_stall)
  );

  // hash, remainder, slot store and result register
  shdt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .VALUE_BITS  (VALUE_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_mode         (in_mode),
    .in_key_char     (in_key_char),
    .in_char_present (in_char_present),
    .in_last_char    (in_last_char),
    .in_write_value  (in_write_value),
    .out_stall       (out_stall),
    .cmd             (cmd),
    .st              (st),
    .out_valid       (out_valid),
    .out_read_value  (out_read_value),
    .out_status      (out_status),
    .out_slot_index  (out_slot_index)
  );

endmodule

// ===== hdl/shdt_checker.sv =====
// Port-level checks for the string hash direct-mapped table, bound to the top level.
`timescale 1ns / 1ps
module shdt_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [shdt_pkg::DATA_W-1:0] out_read_value,
  input logic                        out_status,
  input logic [shdt_pkg::SLOT_W-1:0] out_slot_index
);

  // the store clear holds off input right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> in_stall)
    else $error("input not held off during store clear");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_read_value)
      && $stable(out_status) && $stable(out_slot_index))
    else $error("stalled result changed");

  // a type error never returns data
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status |-> out_read_value == '0)
    else $error("type error with nonzero read value");

  // a result appears only after a last item, while input is held off
  a_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared while input was open");

endmodule

bind string_hash_direct_table shdt_checker u_shdt_checker (.*);

// ===== sim/shdt_table_checker.sv =====
`timescale 1ns / 1ps
// Checker for the string hash table: predicts each result and compares it.
module shdt_table_checker #(
  parameter int MAX_ENTRIES = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic [shdt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [shdt_pkg::CFG_W-1:0]      cfg_wdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [2:0]                      in_mode,
  input  logic [7:0]                      in_key_char,
  input  logic                            in_char_present,
  input  logic                            in_last_char,
  input  logic [shdt_pkg::DATA_W-1:0]     in_write_value,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [shdt_pkg::DATA_W-1:0]     out_read_value,
  input  logic                            out_status,
  input  logic [shdt_pkg::SLOT_W-1:0]     out_slot_index,
  output int                              fail_count,
  output int                              pending
);
  import shdt_pkg::*;

  localparam logic [63:0] HASH_MULT = 64'd97;
  localparam int MAX_PRINTED = 30;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              status;
    logic [SLOT_W-1:0] slot_index;
  } lookup_t;

  lookup_t           lookup_q[$];
  lookup_t           want;
  logic [63:0]       name_hash;
  logic [63:0]       slot_mem [MAX_ENTRIES];
  logic [ENT_W-1:0]  entries_reg;
  logic [EB_W-1:0]   bytes_reg;
  logic              ptr_reg;
  int                mismatches = 0;
  int                queued = 0;

  assign fail_count = mismatches;
  assign pending    = queued;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] wanted);
    if (mismatches < MAX_PRINTED)
      $display("%0t mismatch: %s got %h wanted %h", $realtime, what, got, wanted);
    mismatches++;
  endtask

  // Folds one key character; on the final item runs the table operation.
  task automatic fold_and_lookup(input logic [2:0] op, input logic [7:0] ch,
                                 input logic present, input logic last,
                                 input logic [63:0] wv);
    int          n;
    int          eb;
    logic [63:0] vmask;
    logic [63:0] slot;
    lookup_t     res;
    if (present)
      name_hash = name_hash * HASH_MULT + {56'd0, ch};
    if (last) begin
      n  = (entries_reg == 0) ? 1 :
           (entries_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(entries_reg);
      eb = (bytes_reg == 0) ? 1 : (bytes_reg > 8) ? 8 : int'(bytes_reg);
      // VALUE_BITS is 64, so pointer words keep all bits
      vmask = (eb == 8) ? '1 : (64'd1 << (8 * eb)) - 64'd1;
      slot = name_hash % 64'(n);
      name_hash = '0;
      res = '0;
      res.slot_index = slot[SLOT_W-1:0];
      case (op)
        MODE_SET_VAL: begin
          if (ptr_reg) res.status = 1'b1;
          else slot_mem[slot] = wv & vmask;
        end
        MODE_GET_VAL: begin
          if (ptr_reg) res.status = 1'b1;
          else res.read_value = slot_mem[slot] & vmask;
        end
        MODE_SET_PTR: begin
          if (!ptr_reg) res.status = 1'b1;
          else slot_mem[slot] = wv;
        end
        MODE_GET_PTR: begin
          if (!ptr_reg) res.status = 1'b1;
          else res.read_value = slot_mem[slot];
        end
        MODE_FILL: begin
          res.slot_index = '0;
          if (ptr_reg) res.status = 1'b1;
          else for (int i = 0; i < n; i++) slot_mem[i] = wv & vmask;
        end
        default: res.status = 1'b1;
      endcase
      lookup_q.push_back(res);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      name_hash   = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) slot_mem[i] = '0;
      entries_reg = TABLE_ENTRIES_RST;
      bytes_reg   = ELEMENT_BYTES_RST;
      ptr_reg     = 1'b0;
      lookup_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_TABLE_ENTRIES: entries_reg = cfg_wdata[ENT_W-1:0];
          CFG_ELEMENT_BYTES: bytes_reg   = cfg_wdata[EB_W-1:0];
          CFG_POINTER_MODE:  ptr_reg     = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        fold_and_lookup(in_mode, in_key_char, in_char_present, in_last_char,
                        in_write_value);
      if (out_valid && !out_stall) begin
        if (lookup_q.size() == 0) begin
          report_mismatch("result with none expected", out_read_value, '0);
        end else begin
          want = lookup_q.pop_front();
          if (out_read_value !== want.read_value)
            report_mismatch("read_value", out_read_value, want.read_value);
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_slot_index !== want.slot_index)
            report_mismatch("slot_index", 64'(out_slot_index), 64'(want.slot_index));
        end
      end
    end
    queued = lookup_q.size();
  end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Testbench top: clock, reset, table settings, key stimulus and the verdict.
module tb;
  import shdt_pkg::*;

  // Modes 5..7 are unassigned; the block must answer them with a type error
  localparam logic [2:0] MODE_RSVD_LO = 3'd5;
  localparam logic [2:0] MODE_RSVD_HI = 3'd7;

  localparam int NUM_PHASES      = 8;
  localparam int ITEMS_PER_PHASE = 103;  // random part, per table setting
  localparam int POOL_SIZE       = 8;    // keys reused so gets find earlier sets
  localparam int KEY_MAX         = 24;
  localparam int SETTLE_CYCLES   = 8;    // quiet time before a register write
  localparam int TAIL_CYCLES     = 400;  // covers a full fill walk plus divide

  // Table settings walked in order. Entry count 0 and 511, byte size 0 and 15
  // are out of range and must clamp; 511 and 15 also set every register bit.
  int unsigned phase_entries [NUM_PHASES] = '{256, 1, 0, 511, 7, 256, 1, 100};
  int unsigned phase_bytes   [NUM_PHASES] = '{8, 1, 0, 15, 3, 8, 5, 4};
  bit          phase_ptr     [NUM_PHASES] = '{0, 0, 0, 0, 0, 1, 1, 0};

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [2:0]           in_mode = '0;
  logic [7:0]           in_key_char = '0;
  logic                 in_char_present = 1'b0;
  logic                 in_last_char = 1'b0;
  logic [DATA_W-1:0]    in_write_value = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [DATA_W-1:0]    out_read_value;
  logic                 out_status;
  logic [SLOT_W-1:0]    out_slot_index;
  int                   fail_count;
  int                   pending;

  // Sender pacing and receiver stall pattern
  int unsigned burst_left = 0;
  int unsigned stall_run = 0;
  int unsigned stall_style = 0;
  int          items_sent = 0;

  // Current key and the pool of keys that get revisited
  logic [7:0] key_buf [KEY_MAX];
  int         key_len = 0;
  logic [7:0] key_pool [POOL_SIZE][KEY_MAX];
  int         key_pool_len [POOL_SIZE];

  string_hash_direct_table i_dut (.*);
  shdt_table_checker       i_checker (.*);

  always #5 clk = ~clk;

  // Receiver: runs of random length, each either free-flowing, lightly
  // stalled or mostly stalled, so results wait on every kind of back-pressure.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_style <= $urandom_range(0, 2);
      stall_run   <= $urandom_range(4, 40);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Hard stop in case the block hangs; far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("[string_hash_direct_table] ERROR");
    $finish;
  end

  function automatic logic [63:0] pick_value();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '1;
    if (r == 1) return '0;
    return {$urandom, $urandom};
  endfunction

  // Mostly operations that fit the table type, with some type errors,
  // occasional fills (slow: they walk every slot) and unassigned modes.
  function automatic logic [2:0] pick_op(input bit ptr);
    int r;
    r = $urandom_range(0, 99);
    if (ptr) begin
      if (r < 40) return MODE_SET_PTR;
      if (r < 80) return MODE_GET_PTR;
      if (r < 84) return MODE_SET_VAL;
      if (r < 88) return MODE_GET_VAL;
      if (r < 93) return MODE_FILL;
    end else begin
      if (r < 38) return MODE_SET_VAL;
      if (r < 78) return MODE_GET_VAL;
      if (r < 85) return MODE_FILL;
      if (r < 89) return MODE_SET_PTR;
      if (r < 94) return MODE_GET_PTR;
    end
    return 3'($urandom_range(MODE_RSVD_LO, MODE_RSVD_HI));
  endfunction

  // Drives one item and returns at the edge where it is taken. Between bursts
  // valid drops for a random gap; about a quarter of bursts follow back to back.
  task automatic send_item(input logic [2:0] op, input logic [7:0] ch,
                           input logic present, input logic last,
                           input logic [63:0] wval);
    bit          took;
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid        <= 1'b1;
    in_mode         <= op;
    in_key_char     <= ch;
    in_char_present <= present;
    in_last_char    <= last;
    in_write_value  <= wval;
    // stall is stable at the falling edge; the next rising edge is the transfer
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    if (present || last) items_sent++;
  endtask

  // Sends key_buf as one name. With merge_last the final character rides on
  // the operation item; otherwise a bare last item follows. Both hash the same.
  // Now and then an item without a character is slipped in as noise.
  task automatic run_op(input logic [2:0] op, input logic [63:0] wval,
                        input bit merge_last);
    for (int i = 0; i < key_len; i++) begin
      if ($urandom_range(0, 19) == 0)
        send_item(3'($urandom), 8'($urandom), 1'b0, 1'b0, pick_value());
      if (merge_last && i == key_len - 1)
        send_item(op, key_buf[i], 1'b1, 1'b1, wval);
      else
        send_item(3'($urandom), key_buf[i], 1'b1, 1'b0, pick_value());
    end
    if (!(merge_last && key_len > 0))
      send_item(op, 8'($urandom), 1'b0, 1'b1, wval);
  endtask

  // Holds the sender off until every result is back.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Register writes on back-to-back edges; unused upper data bits are random.
  task automatic program_table(input int unsigned ent, input int unsigned eb,
                               input bit ptr);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_TABLE_ENTRIES;
    cfg_wdata <= CFG_W'(ent);
    @(posedge clk);
    cfg_index <= CFG_ELEMENT_BYTES;
    cfg_wdata <= {5'($urandom), 4'(eb)};
    @(posedge clk);
    cfg_index <= CFG_POINTER_MODE;
    cfg_wdata <= {8'($urandom), ptr};
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic seed_pool();
    for (int p = 0; p < POOL_SIZE; p++) begin
      key_pool_len[p] = $urandom_range(1, 5);
      for (int i = 0; i < KEY_MAX; i++) key_pool[p][i] = 8'($urandom);
    end
  endtask

  // Two thirds of names come from the pool; the rest are fresh, mostly short,
  // some long enough for the hash to wrap past 64 bits. Fresh names, empty
  // ones included, replace a pool entry.
  task automatic choose_key();
    int r;
    int p;
    r = $urandom_range(0, 99);
    p = $urandom_range(0, POOL_SIZE - 1);
    if (r >= 65) begin
      key_pool_len[p] = (r < 90) ? $urandom_range(0, 6) : $urandom_range(10, KEY_MAX);
      for (int i = 0; i < KEY_MAX; i++) key_pool[p][i] = 8'($urandom);
    end
    key_len = key_pool_len[p];
    for (int i = 0; i < KEY_MAX; i++) key_buf[i] = key_pool[p][i];
  endtask

  // Directed names under the reset setting (256 entries, 8 bytes, values).
  task automatic run_directed();
    key_len = 1;
    key_buf[0] = 8'h41;
    run_op(MODE_SET_VAL, '1, 1'b1);
    run_op(MODE_GET_VAL, '0, 1'b0);
    // empty name lands in slot 0
    key_len = 0;
    run_op(MODE_SET_VAL, 64'h0123_4567_89AB_CDEF, 1'b0);
    run_op(MODE_GET_VAL, '0, 1'b0);
    // extreme characters, a zero byte folded in as well
    key_len = 2;
    key_buf[0] = 8'hFF;
    key_buf[1] = 8'h00;
    run_op(MODE_SET_VAL, 64'h8000_0000_0000_0001, 1'b1);
    // pointer operations on a value table are type errors
    run_op(MODE_GET_PTR, '1, 1'b1);
    run_op(MODE_SET_PTR, '1, 1'b1);
    key_len = 0;
    for (int m = MODE_RSVD_LO; m <= MODE_RSVD_HI; m++) run_op(3'(m), '1, 1'b0);
    // fill carrying a character: folded, then dropped with the hash
    key_len = 1;
    key_buf[0] = 8'h7E;
    run_op(MODE_FILL, 64'hA5A5_A5A5_A5A5_A5A5, 1'b1);
    // ten bytes of 0xFF wrap the hash; the slot holds the fill value
    key_len = 10;
    for (int i = 0; i < 10; i++) key_buf[i] = 8'hFF;
    run_op(MODE_GET_VAL, '0, 1'b1);
  endtask

  initial begin
    int  phase_end;
    int  halfway;
    bit  paused;
    // reset is held low from the start; the block then clears its store
    // with in_stall high, which the handshake simply waits out
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    for (int p = 0; p < NUM_PHASES; p++) begin
      if (p > 0) begin
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
      end
      program_table(phase_entries[p], phase_bytes[p], phase_ptr[p]);
      if (p == 0) run_directed();
      seed_pool();
      phase_end = items_sent + ITEMS_PER_PHASE;
      halfway   = items_sent + ITEMS_PER_PHASE / 2;
      paused    = 1'b0;
      while (items_sent < phase_end) begin
        // once per setting the sender waits for the pipe to empty
        if (!paused && items_sent >= halfway) begin
          drain_results();
          paused = 1'b1;
        end
        choose_key();
        run_op(pick_op(phase_ptr[p]), pick_value(), 1'($urandom));
      end
    end
    drain_results();
    // any stray result would show up in this window
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("[string_hash_direct_table] OK");
    else
      $display("[string_hash_direct_table] ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/shdt_pkg.sv
hdl/shdt_ctrl.sv
hdl/shdt_datapath.sv
hdl/string_hash_direct_table.sv
hdl/shdt_checker.sv
sim/shdt_table_checker.sv
sim/tb.sv
